@@ sv/vpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// vpmc_pkg
// Shared constants and register codes of the Voigt profile convolution core.
// ----------------------------------------------------------------------------
package vpmc_pkg;

  // floor(2^32 / (2 pi)) and round(2^32 / sqrt(2 pi))
  localparam logic [29:0] INV_TWO_PI_Q32      = 30'd683565275;
  localparam logic [30:0] INV_SQRT_TWO_PI_Q32 = 31'd1713444047;

  // distance limit before squaring, 2^30 - 1 in Q16.16
  localparam logic [29:0] D_LIMIT = 30'h3FFF_FFFF;

  // terms of the exp series
  localparam int EXP_TERMS = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_SIGMA  = 2'd1,
    REG_WIDTH  = 2'd2
  } cfg_reg_t;

endpackage

@@ sv/voigt_profile_midpoint_convolution_core.sv @@
// ----------------------------------------------------------------------------
// voigt_profile_midpoint_convolution_core
// Midpoint-rule convolution of a Lorentzian with a Gaussian, one point a cycle unless held.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  in       | in_valid / in_stall   | energy
//  out      | out_valid / out_stall | amplitude, saturated
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  each energy occupies the issue stage for NUM_POINTS integration points,
//  one per cycle unless held; the next beat is taken with the last point
//  from the last point, the result passes through the 32-stage Lorentzian
//  divider and the weighting stages before the sum is complete
//  reset and each sigma write stall the input while the per-point offset
//  step is worked out by reciprocal multiplication
//  reset clears valid bits and loads the register defaults; no clearing pass
//  the whole pipeline holds only when a finished sum meets a full output slot
// ----------------------------------------------------------------------------
module voigt_profile_midpoint_convolution_core #(
  parameter int NUM_POINTS      = 100,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] energy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] amplitude,
  output logic        saturated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(NUM_POINTS);
  localparam int AW = 32 + IW;
  localparam int SH = 33 + $clog2(NUM_POINTS);
  localparam longint NN = longint'(NUM_POINTS) * longint'(NUM_POINTS);
  localparam logic [64:0] ONE_Q32 = 65'h1_0000_0000;
  // ceil(2^SH / NUM_POINTS), exact quotient for any 33-bit span
  localparam logic [34:0] RECIP =
    35'(((64'd1 << SH) + 64'(NUM_POINTS) - 64'd1) / 64'(NUM_POINTS));

  typedef struct packed {
    logic          last;
    logic [IW-1:0] idx;
    logic          zero;
    logic [62:0]   den;
    logic [62:0]   r;
    logic [31:0]   nq;
  } bdiv_t;

  // gaussian weight of point idx, worked out at elaboration
  function automatic logic [31:0] weight_of(input int idx);
    int          mi;
    int          j;
    logic [64:0] m;
    logic [64:0] k;
    logic [64:0] f;
    logic [64:0] acc;
    mi = NUM_POINTS - 1 - 2 * idx;
    m = 65'(mi < 0 ? -mi : mi);
    k = (65'(EXP_TABLE_DEPTH) * m * m + 65'(NN / 2)) / 65'(NN);
    if (k >= 65'(EXP_TABLE_DEPTH)) k = 65'(EXP_TABLE_DEPTH - 1);
    f = (k << 32) / EXP_TABLE_DEPTH;
    if (f > 65'hFFFF_FFFF) f = 65'hFFFF_FFFF;
    acc = ONE_Q32;
    for (j = vpmc_pkg::EXP_TERMS; j >= 1; j--) begin
      acc = ONE_Q32 - (((f * acc) >> 32) / 65'(j));
    end
    if (acc > 65'hFFFF_FFFF) acc = 65'hFFFF_FFFF;
    for (j = 0; j < 3; j++) begin
      acc = (acc * acc) >> 32;
    end
    acc = (acc * 65'(vpmc_pkg::INV_SQRT_TWO_PI_Q32)) >> 32;
    return 32'((acc * 65'd8) / NUM_POINTS);
  endfunction

  // one quotient bit of the lorentzian division
  function automatic bdiv_t bdiv_step(input bdiv_t a);
    bdiv_t       o;
    logic [63:0] r2;
    logic [63:0] rn;
    logic        ge;
    o = a;
    r2 = {a.r, a.nq[31]};
    ge = r2 >= {1'b0, a.den};
    rn = ge ? r2 - {1'b0, a.den} : r2;
    o.r = rn[62:0];
    o.nq = {a.nq[30:0], ge};
    return o;
  endfunction

  // configuration registers
  logic signed [31:0] center;
  logic [30:0]        sigma;
  logic [30:0]        gwidth;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= 32'sd209715;
      sigma  <= 31'd9175;
      gwidth <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        vpmc_pkg::REG_CENTER: center <= cfg_data;
        vpmc_pkg::REG_SIGMA:  sigma  <= cfg_data[30:0];
        vpmc_pkg::REG_WIDTH:  gwidth <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // weight table
  logic [31:0] w_rom [NUM_POINTS];
  for (genvar gi = 0; gi < NUM_POINTS; gi++) begin : g_wt
    localparam logic [31:0] WV = weight_of(gi);
    assign w_rom[gi] = WV;
  end

  // pipeline state
  logic          en;
  logic          accept;
  logic          last_pt;
  logic          busy;
  logic [IW-1:0] cnt;
  logic signed [35:0] base_r;
  logic [32:0]   q_span;
  logic [33:0]   tq;
  logic [IW-1:0] tr;
  logic [IW:0]   rsum;
  logic          rc;

  // offset step preparation
  logic          prep_go;
  logic [2:0]    prep_v;
  logic          prep_busy;
  logic [50:0]   pm_lo;
  logic [49:0]   pm_hi;
  logic [67:0]   pfull;
  logic [33:0]   q0;
  logic [33:0]   q0n;
  logic [IW-1:0] r0;
  logic [IW:0]   r0x;
  logic          r0ge;
  logic [33:0]   step_q;
  logic [IW-1:0] step_r;

  logic          a_v, m_v, n_v, w_v, p_v;
  logic          a_last, m_last, w_last, p_last;
  logic [IW-1:0] a_idx, m_idx;
  logic [29:0]   a_ad;
  logic [59:0]   m_sq;
  logic [61:0]   m_gg;
  logic [60:0]   m_num;
  bdiv_t         bin;
  logic [32:1]   bv;
  bdiv_t         bst [1:32];
  logic [31:0]   w_bw;
  logic [31:0]   w_wt;
  logic [31:0]   p_term;
  logic [AW-1:0] acc;

  logic signed [36:0]   dval;
  logic [36:0]          dmag;
  logic [29:0]          ad_c;
  logic [62:0]          den_c;
  logic [62:0]          num4;
  logic [63:0]          prod;
  logic [AW-1:0]        sum;

  // handshake and stall
  assign q_span    = {sigma, 2'b00};
  assign prep_busy = prep_go || (|prep_v);
  assign en        = !(out_valid && out_stall && p_v && p_last);
  assign last_pt   = busy && (cnt == IW'(NUM_POINTS - 1));
  assign in_stall  = !en || prep_busy || (busy && !last_pt);
  assign accept    = in_valid && !in_stall;

  // step tracking after reset and sigma writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_go <= 1'b1;
      prep_v  <= '0;
    end else begin
      prep_go <= cfg_we && (cfg_index == vpmc_pkg::REG_SIGMA);
      prep_v  <= {prep_v[1:0], prep_go};
    end
  end

  // span over point count as quotient and remainder
  assign pfull = {pm_hi, 18'b0} + 68'(pm_lo);
  assign q0n   = q0 * 34'(NUM_POINTS);
  assign r0x   = {r0, 1'b0};
  assign r0ge  = r0x >= (IW+1)'(NUM_POINTS);

  always_ff @(posedge clk) begin
    pm_lo  <= 51'(q_span) * 51'(RECIP[17:0]);
    pm_hi  <= 50'(q_span) * 50'(RECIP[34:18]);
    q0     <= 34'(pfull >> SH);
    r0     <= IW'({1'b0, q_span} - q0n);
    step_q <= {q0[32:0], 1'b0} + 34'(r0ge);
    step_r <= r0ge ? IW'(r0x - (IW+1)'(NUM_POINTS)) : IW'(r0x);
  end

  // next offset remainder
  always_comb begin
    rsum = {1'b0, tr} + {1'b0, step_r};
    rc   = rsum >= (IW+1)'(NUM_POINTS);
  end

  // issue stage: one integration point per cycle unless held
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en) begin
      if (accept) busy <= 1'b1;
      else if (last_pt) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept) begin
        cnt    <= '0;
        tq     <= q0;
        tr     <= r0;
        base_r <= 36'(signed'(energy)) - 36'(center) - $signed({3'b000, q_span});
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        tq  <= tq + step_q + 34'(rc);
        tr  <= rc ? IW'(rsum - (IW+1)'(NUM_POINTS)) : IW'(rsum);
      end
    end
  end

  // distance from the resonance, clamped
  always_comb begin
    dval = $signed({base_r[35], base_r}) + $signed({3'b000, tq});
    dmag = dval[36] ? 37'(-dval) : 37'(dval);
    ad_c = (dmag > 37'(vpmc_pkg::D_LIMIT)) ? vpmc_pkg::D_LIMIT : dmag[29:0];
  end

  // lorentzian operands
  assign den_c = 63'({m_sq, 2'b00}) + 63'(m_gg);
  assign num4  = {m_num, 2'b00};
  assign prod  = 64'(w_bw) * 64'(w_wt);
  assign sum   = acc + AW'(p_term);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      m_v <= 1'b0;
      n_v <= 1'b0;
      bv  <= '0;
      w_v <= 1'b0;
      p_v <= 1'b0;
    end else if (en) begin
      a_v <= busy;
      m_v <= a_v;
      n_v <= m_v;
      bv  <= {bv[31:1], n_v};
      w_v <= bv[32];
      p_v <= w_v;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_last <= last_pt;
      a_idx  <= cnt;
      a_ad   <= ad_c;
      m_last <= a_last;
      m_idx  <= a_idx;
      m_sq   <= 60'(a_ad) * 60'(a_ad);
      m_gg   <= 62'(gwidth) * 62'(gwidth);
      m_num  <= 61'(gwidth) * 61'(vpmc_pkg::INV_TWO_PI_Q32);
      bin.last <= m_last;
      bin.idx  <= m_idx;
      bin.zero <= den_c == '0;
      bin.den  <= den_c;
      bin.r    <= 63'(num4[62:32]);
      bin.nq   <= num4[31:0];
      bst[1] <= bdiv_step(bin);
      for (int j = 2; j <= 32; j++) begin
        bst[j] <= bdiv_step(bst[j-1]);
      end
      w_last <= bst[32].last;
      w_bw   <= bst[32].zero ? '0 : bst[32].nq;
      w_wt   <= w_rom[bst[32].idx];
      p_last <= w_last;
      p_term <= prod[63:32];
    end
  end

  // accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en && p_v) begin
      acc <= p_last ? '0 : sum;
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && p_v && p_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p_v && p_last) begin
      saturated <= |sum[AW-1:32];
      amplitude <= (|sum[AW-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  // checks
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> amplitude == 32'hFFFF_FFFF)
    else $error("saturated beat without clipped amplitude");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= IW'(NUM_POINTS - 1))
    else $error("point counter out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cnt) && $stable(bv) && $stable(acc))
    else $error("pipeline moved while held");

endmodule
